// ===== design/lpd_pkg.sv =====
// Shared types and constants of the length-prefix deframer.
package lpd_pkg;

  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindEmpty   = 2'd1;
  localparam logic [1:0] KindError   = 2'd2;

  localparam logic [31:0] LenMaxNarrow = 32'h0000_FFFF;
  localparam logic [31:0] LenMaxWide   = 32'd3145728;

  localparam logic [2:0] HdrBytesNarrow = 3'd2;
  localparam logic [2:0] HdrBytesWide   = 3'd4;

  localparam int unsigned LeftWidth = 22;
  localparam int unsigned FifoDepth = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

// ===== design/length_prefix_deframer_unit.sv =====
// Top level of the length-prefix deframer: configuration register and stage wiring.
//
// The deframer splits a byte stream into messages that each start with a
// big-endian length header of two or four bytes. Bytes enter on the input
// channel (in_valid_i, in_stall_o, data_byte_i); one transfer moves one byte.
// Results leave on the output channel (out_valid_o, out_stall_i, result_kind_o,
// out_byte_o, last_in_frame_o): a payload byte, an empty-frame marker or a
// length error. Header bytes that do not end in an error or empty frame give
// no result. The header width is set through the configuration channel
// (cfg_valid_i, cfg_ready_o, cfg_header_wide_i), which is always ready. The user must
// write it only while no result is outstanding; the block does not enforce this.
// One byte is taken every cycle while in_stall_o is low. A result is written
// into the queue at the edge of the transfer that caused it; from the queue it
// is loaded into the output register, from which it leaves on the output
// channel. The front end and the output register are parted by a result
// queue of Depth entries; when the receiver stalls, the queue fills and then
// the input channel is stalled, so nothing is lost.
// Reset clears the header collector, the payload counter, the queue and the
// configuration register (two-byte headers).
module length_prefix_deframer_unit #(
  parameter int unsigned Depth = lpd_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_header_wide_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_in_frame_o
);

  logic             header_wide_q;
  logic             fifo_full;
  logic             accept;
  logic             push;
  logic             pop;
  logic             fifo_rvalid;
  lpd_pkg::result_t front_res;
  lpd_pkg::result_t fifo_res;

  // The configuration register can be written in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_wide_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      header_wide_q <= cfg_header_wide_i;
    end
  end

  // A byte is taken only while the queue has room for whatever it may produce.
  assign in_stall_o = fifo_full;
  assign accept     = in_valid_i && !in_stall_o;

  lpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .header_wide_i(header_wide_q),
    .push_o       (push),
    .result_o     (front_res)
  );

  lpd_fifo #(
    .Depth(Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_res),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .rvalid_o(fifo_rvalid),
    .rdata_o (fifo_res)
  );

  lpd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rvalid_i       (fifo_rvalid),
    .rdata_i        (fifo_res),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .out_byte_o     (out_byte_o),
    .last_in_frame_o(last_in_frame_o)
  );

endmodule

// ===== design/lpd_front.sv =====
// Front end: collects length headers, checks them and classifies payload bytes.
module lpd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             header_wide_i,
  output logic             push_o,
  output lpd_pkg::result_t result_o
);

  logic                            in_payload_q, in_payload_d;
  logic [2:0]                      hdr_count_q, hdr_count_d;
  logic [31:0]                     hdr_accum_q, hdr_accum_d;
  logic [lpd_pkg::LeftWidth-1:0]   left_q, left_d;

  logic [lpd_pkg::LeftWidth-1:0]   left_dec;
  logic [31:0]                     accum_next;
  logic [2:0]                      count_next;
  logic [2:0]                      need;
  logic [31:0]                     len;
  logic                            len_ok;
  logic                            has_result;
  lpd_pkg::result_t                res;

  always_comb begin
    in_payload_d = in_payload_q;
    hdr_count_d  = hdr_count_q;
    hdr_accum_d  = hdr_accum_q;
    left_d       = left_q;
    has_result   = 1'b0;
    res          = '0;

    left_dec   = (left_q != '0) ? left_q - 1'b1 : left_q;
    accum_next = {hdr_accum_q[23:0], data_byte_i};
    count_next = hdr_count_q + 3'd1;
    need       = header_wide_i ? lpd_pkg::HdrBytesWide : lpd_pkg::HdrBytesNarrow;
    len        = header_wide_i ? accum_next : (accum_next & lpd_pkg::LenMaxNarrow);
    len_ok     = !header_wide_i || (!accum_next[31] && (accum_next <= lpd_pkg::LenMaxWide));

    if (accept_i) begin
      if (in_payload_q) begin
        has_result = 1'b1;
        res.kind   = lpd_pkg::KindPayload;
        res.data   = data_byte_i;
        res.last   = (left_dec == '0);
        if (left_dec == '0) begin
          in_payload_d = 1'b0;
          hdr_count_d  = '0;
          hdr_accum_d  = '0;
          left_d       = '0;
        end else begin
          left_d = left_dec;
        end
      end else if (count_next < need) begin
        hdr_accum_d = accum_next;
        hdr_count_d = count_next;
      end else begin
        hdr_count_d = '0;
        hdr_accum_d = '0;
        if (!len_ok) begin
          has_result = 1'b1;
          res.kind   = lpd_pkg::KindError;
          left_d     = '0;
        end else if (len == '0) begin
          has_result = 1'b1;
          res.kind   = lpd_pkg::KindEmpty;
          left_d     = '0;
        end else begin
          in_payload_d = 1'b1;
          left_d       = len[lpd_pkg::LeftWidth-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_count_q  <= '0;
      hdr_accum_q  <= '0;
      left_q       <= '0;
    end else begin
      in_payload_q <= in_payload_d;
      hdr_count_q  <= hdr_count_d;
      hdr_accum_q  <= hdr_accum_d;
      left_q       <= left_d;
    end
  end

  assign push_o   = has_result;
  assign result_o = res;

  // While payload is streaming the header collector is cleared and bytes remain.
  a_payload_hdr_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (hdr_count_q == '0) && (hdr_accum_q == '0))
    else $error("header state not cleared during payload");

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (left_q != '0))
    else $error("payload mode with no bytes left");

  a_idle_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_payload_q |-> (left_q == '0))
    else $error("stale payload count while awaiting header");

endmodule

// ===== design/lpd_fifo.sv =====
// Small result queue between the front end and the output stage.
module lpd_fifo #(
  parameter int unsigned Depth = lpd_pkg::FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lpd_pkg::result_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             rvalid_o,
  output lpd_pkg::result_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lpd_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && rvalid_o;
  assign full_o   = (count_q == CntW'(Depth));
  assign rvalid_o = (count_q != '0);
  assign rdata_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("result pushed into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> rvalid_o)
    else $error("pop from an empty queue");

endmodule

// ===== design/lpd_back.sv =====
// Output stage: holds one result in a register until the receiver takes it.
module lpd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rvalid_i,
  input  lpd_pkg::result_t rdata_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       out_byte_o,
  output logic             last_in_frame_o
);

  logic             valid_q, valid_d;
  lpd_pkg::result_t res_q;
  logic             load;

  assign load    = rvalid_i && (!valid_q || !out_stall_i);
  assign pop_o   = load;
  assign valid_d = load ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= rdata_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign result_kind_o   = res_q.kind;
  assign out_byte_o      = res_q.data;
  assign last_in_frame_o = res_q.last;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the length-prefix deframer top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Receiver stalls and sender gaps both use this rate, in percent.
  localparam int unsigned IdlePercent  = 13;
  // Cycles to let pass once no result is outstanding. This covers the output
  // register plus the result queue, so trailing header bytes have settled.
  localparam int unsigned SettleCycles = 2 * lpd_pkg::FifoDepth + 4;
  // Cycles without any transfer after which the run is declared hung.
  localparam int unsigned HangLimit    = 2000;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseBytes   = 125;
  localparam int unsigned QuietPhase   = 3;  // no gaps and no stalls here

  // A directed row is either a stream byte or a header width write. Rows
  // whose result is obvious carry it typed in. All other rows rely on the
  // predictor.
  typedef enum logic {RowData, RowWidth} row_op_e;

  typedef struct packed {
    row_op_e          op;
    logic [7:0]       value;
    logic             typed;
    lpd_pkg::result_t want;
  } stim_row_t;

  localparam lpd_pkg::result_t NoResult = '0;

  localparam stim_row_t DirectedRows [26] = '{
    // Right after reset the header is two bytes wide, and a zero length
    // gives an empty frame.
    '{RowData,  8'h00, 1'b0, NoResult},
    '{RowData,  8'h00, 1'b1, '{lpd_pkg::KindEmpty, 8'h00, 1'b0}},
    // A two-byte frame of length two. The width is switched to four bytes
    // between its payload bytes, and this must not disturb the frame.
    '{RowData,  8'h00, 1'b0, NoResult},
    '{RowData,  8'h02, 1'b0, NoResult},
    '{RowData,  8'h11, 1'b1, '{lpd_pkg::KindPayload, 8'h11, 1'b0}},
    '{RowWidth, 8'h01, 1'b0, NoResult},
    '{RowData,  8'h22, 1'b1, '{lpd_pkg::KindPayload, 8'h22, 1'b1}},
    // Four-byte header with every bit set. This is a negative length.
    '{RowData,  8'hFF, 1'b0, NoResult},
    '{RowData,  8'hFF, 1'b0, NoResult},
    '{RowData,  8'hFF, 1'b0, NoResult},
    '{RowData,  8'hFF, 1'b1, '{lpd_pkg::KindError, 8'h00, 1'b0}},
    // One more than the four-byte limit.
    '{RowData,  8'h00, 1'b0, NoResult},
    '{RowData,  8'h30, 1'b0, NoResult},
    '{RowData,  8'h00, 1'b0, NoResult},
    '{RowData,  8'h01, 1'b1, '{lpd_pkg::KindError, 8'h00, 1'b0}},
    // A four-byte frame of length one, carrying the largest byte value.
    '{RowData,  8'h00, 1'b0, NoResult},
    '{RowData,  8'h00, 1'b0, NoResult},
    '{RowData,  8'h00, 1'b0, NoResult},
    '{RowData,  8'h01, 1'b0, NoResult},
    '{RowData,  8'hFF, 1'b1, '{lpd_pkg::KindPayload, 8'hFF, 1'b1}},
    // Three header bytes are collected in four-byte mode, and then the width
    // drops to two. The next byte completes the header from the low 16 bits.
    '{RowData,  8'h00, 1'b0, NoResult},
    '{RowData,  8'h00, 1'b0, NoResult},
    '{RowData,  8'h00, 1'b0, NoResult},
    '{RowWidth, 8'h00, 1'b0, NoResult},
    '{RowData,  8'h01, 1'b0, NoResult},
    '{RowData,  8'h7E, 1'b0, NoResult}
  };

  logic       clk_i             = 1'b0;
  logic       rst_ni            = 1'b0;
  logic       cfg_valid_i       = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_header_wide_i = 1'b0;
  logic       in_valid_i        = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i       = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i       = 1'b0;
  logic [1:0] result_kind_o;
  logic [7:0] out_byte_o;
  logic       last_in_frame_o;

  length_prefix_deframer_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_header_wide_i(cfg_header_wide_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .out_byte_o       (out_byte_o),
    .last_in_frame_o  (last_in_frame_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // This is the testbench's own copy of the deframer state. The monitor
  // advances it on every accepted transfer.
  logic                          hdr_wide    = 1'b0;
  logic                          body_active = 1'b0;
  logic [2:0]                    hdr_count   = '0;
  logic [31:0]                   hdr_accum   = '0;
  logic [lpd_pkg::LeftWidth-1:0] body_left   = '0;

  lpd_pkg::result_t expected_results [$];
  logic             row_typed = 1'b0;
  lpd_pkg::result_t row_want  = '0;
  logic        gaps_enabled   = 1'b1;
  logic        stalls_enabled = 1'b1;
  int unsigned items_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned payload_seen = 0;
  int unsigned empty_seen   = 0;
  int unsigned error_seen   = 0;

  function automatic void clear_frame_state();
    body_active = 1'b0;
    hdr_count   = '0;
    hdr_accum   = '0;
    body_left   = '0;
  endfunction

  // Advances the predicted state by one stream byte. The function returns 1
  // when the byte yields a result, and that result is placed in res.
  function automatic logic deframe_byte(input logic [7:0] b,
                                        output lpd_pkg::result_t res);
    logic [2:0]  need;
    logic [31:0] len;
    logic        ok;
    res = '0;
    if (body_active) begin
      // The counter saturates at zero. A payload byte with nothing left
      // still closes the frame.
      if (body_left != '0) body_left = body_left - 1'b1;
      res.kind = lpd_pkg::KindPayload;
      res.data = b;
      res.last = (body_left == '0);
      if (res.last) clear_frame_state();
      return 1'b1;
    end
    hdr_accum = {hdr_accum[23:0], b};
    hdr_count = hdr_count + 3'd1;
    need = hdr_wide ? lpd_pkg::HdrBytesWide : lpd_pkg::HdrBytesNarrow;
    // Completion is checked against the width in force now. This lets a
    // width change in the middle of a header end that header early.
    if (hdr_count < need) return 1'b0;
    if (hdr_wide) begin
      len = hdr_accum;
      ok  = !len[31] && (len <= lpd_pkg::LenMaxWide);
    end else begin
      len = hdr_accum & lpd_pkg::LenMaxNarrow;
      ok  = 1'b1;
    end
    if (!ok || len == '0) begin
      clear_frame_state();
      res.kind = ok ? lpd_pkg::KindEmpty : lpd_pkg::KindError;
      return 1'b1;
    end
    hdr_count   = '0;
    hdr_accum   = '0;
    body_active = 1'b1;
    body_left   = len[lpd_pkg::LeftWidth-1:0];
    return 1'b0;
  endfunction

  // This block runs at the rising edge, so it sees the values from before the
  // edge on every channel. It updates the predictor and checks results. It
  // also acts as the hang watchdog.
  always @(posedge clk_i) begin
    lpd_pkg::result_t predicted, got, want;
    logic    produced, moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        hdr_wide = cfg_header_wide_i;
        moved    = 1'b1;
      end
      if (in_valid_i && !in_stall_o) begin
        produced = deframe_byte(data_byte_i, predicted);
        if (row_typed) expected_results.push_back(row_want);
        else if (produced) expected_results.push_back(predicted);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        got.kind = result_kind_o;
        got.data = out_byte_o;
        got.last = last_in_frame_o;
        moved    = 1'b1;
        if (got.kind == lpd_pkg::KindPayload) payload_seen++;
        else if (got.kind == lpd_pkg::KindEmpty) empty_seen++;
        else error_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, kind %0d byte %02h last %0b",
                   $time, got.kind, got.data, got.last);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind) begin
            $display("%0t: result_kind expected %0d, got %0d", $time, want.kind, got.kind);
            mismatches++;
          end
          if (got.data !== want.data) begin
            $display("%0t: out_byte expected %02h, got %02h", $time, want.data, got.data);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_in_frame expected %0b, got %0b", $time, want.last, got.last);
            mismatches++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= HangLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, HangLimit);
        $display("length_prefix_deframer_unit: mismatch");
        $finish;
      end
    end
  end

  // The receiver stalls at random, except in the quiet phase.
  always @(negedge clk_i) begin
    out_stall_i <= stalls_enabled && ($urandom_range(99) < IdlePercent);
  end

  // This task offers one byte after an optional random gap. It holds the byte
  // until the transfer happens and returns at the next falling edge with valid
  // still high. The caller's next action then sets valid once in that step.
  task automatic send_byte(input logic [7:0] b);
    while (gaps_enabled && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // The sender pauses until every expected result has arrived. Then it gives
  // the block time to absorb trailing header bytes, which cause no result.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_header_width(input logic wide);
    cfg_valid_i       <= 1'b1;
    cfg_header_wide_i <= wide;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // This task sends a big-endian header at the current width.
  task automatic send_header(input logic [31:0] value);
    for (int i = hdr_wide ? 3 : 1; i >= 0; i--) send_byte(value[8*i +: 8]);
  endtask

  task automatic send_message(input int unsigned len);
    send_header(len);
    repeat (len) send_byte(8'($urandom_range(255)));
  endtask

  // Most frames are short, some are empty, and a few reach a few hundred bytes.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 85) return $urandom_range(16, 1);
    return $urandom_range(400, 17);
  endfunction

  initial begin
    stim_row_t   row;
    int unsigned phase_start, len, r;
    logic [31:0] bad;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirectedRows[i]) begin
      row = DirectedRows[i];
      if (row.op == RowWidth) begin
        wait_idle();
        write_header_width(row.value[0]);
      end else begin
        row_typed = row.typed;
        row_want  = row.want;
        send_byte(row.value);
      end
    end
    row_typed = 1'b0;

    // In the random part each phase starts from an idle block with a fresh
    // width. Most traffic is well-formed frames with random content. In
    // four-byte mode some headers are out of range or negative, and a phase
    // may end in the middle of a header or a payload.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_idle();
      gaps_enabled   = (phase != QuietPhase);
      stalls_enabled = (phase != QuietPhase);
      write_header_width(1'($urandom_range(1)));

      // Any frame cut short by the last phase is finished under the new
      // width. Cut headers hold only zero bytes, so the length that ends up
      // decoded stays small.
      while (body_active) send_byte(8'($urandom_range(255)));
      if (hdr_count != 0) begin
        while (hdr_count + 1 < (hdr_wide ? lpd_pkg::HdrBytesWide : lpd_pkg::HdrBytesNarrow))
          send_byte(8'h00);
        send_byte(8'($urandom_range(15)));
        while (body_active) send_byte(8'($urandom_range(255)));
      end

      phase_start = items_sent;
      while (items_sent - phase_start < PhaseBytes) begin
        if (hdr_wide && $urandom_range(99) < 12) begin
          bad = $urandom_range(1) ? {1'b1, 31'($urandom)}
              : lpd_pkg::LenMaxWide + 1
                + $urandom_range(32'h7FFF_FFFF - lpd_pkg::LenMaxWide - 1);
          send_header(bad);
        end else begin
          send_message(pick_length());
        end
      end

      r = $urandom_range(99);
      if (r < 30) begin
        repeat ($urandom_range(hdr_wide ? 3 : 1, 1)) send_byte(8'h00);
      end else if (r < 60) begin
        len = $urandom_range(16, 2);
        send_header(len);
        repeat ($urandom_range(len - 1, 1)) send_byte(8'($urandom_range(255)));
      end
    end

    wait_idle();
    $display("Sent %0d bytes in both header widths, with frames cut across width changes.",
             items_sent);
    $display("Checked %0d payload bytes, %0d empty frames and %0d length errors.",
             payload_seen, empty_seen, error_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("length_prefix_deframer_unit: match");
    end else begin
      $display("length_prefix_deframer_unit: mismatch");
    end
    $finish;
  end

endmodule
